// ----- rtl/core/dmm_pkg.sv -----
// ----------------------------------------------------------------------------
// dmm_pkg
// Shared types and constants of the dilated mask merge block: item formats,
// register codes, line memory word and the control bundles between stages.
// ----------------------------------------------------------------------------
package dmm_pkg;

  // frame geometry
  localparam int unsigned MAX_WIDTH    = 1024;
  localparam int unsigned HEIGHT_LIMIT = 1024;
  localparam int unsigned COL_W        = $clog2(MAX_WIDTH);
  localparam int unsigned OUT_ROW_W    = $clog2(HEIGHT_LIMIT);
  // input row runs up to two rows past the frame while the tail drains
  localparam int unsigned IN_ROW_W     = $clog2(HEIGHT_LIMIT + 2);
  localparam int unsigned SIZE_W       = 11;

  // configuration port
  localparam int unsigned CFG_IDX_W = 2;

  // pixels
  localparam int unsigned PIX_W    = 8;
  localparam logic [PIX_W-1:0] FG_VALUE = 8'd255;

  // result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_PASS_MODE    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_MERGE      = 2'd0,
    MODE_PASS_DIFF  = 2'd1,
    MODE_PASS_MODEL = 2'd2
  } pass_mode_e;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] model_pixel;
    logic [PIX_W-1:0] diff_pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] fg_pixel;
    logic             merge_mark;
    logic             frame_last;
  } out_item_t;

  // centre entry: value to output and difference mask foreground flag
  typedef struct packed {
    logic             diff_fg;
    logic [PIX_W-1:0] value;
  } centre_t;

  // one column of the line memory: model hits of the two rows above and
  // the centre entry of the row above
  typedef struct packed {
    logic    hit_up1;
    logic    hit_up2;
    centre_t centre;
  } line_word_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
  } rd_req_t;

  // item in the memory stage
  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] col;
    logic             cur_hit;
    centre_t          cur_centre;
    logic             row_ge1;
    logic             row_ge2;
    logic             emit;
    logic             left_ok;
    logic             right_ok;
    logic             last;
    logic             single;
  } mem_item_t;

endpackage

// ----- rtl/core/dmm_ctrl.sv -----
// ----------------------------------------------------------------------------
// dmm_ctrl
// Configuration registers, input and output raster counters, input flow
// control and issue of the line memory read for each accepted transaction.
// ----------------------------------------------------------------------------
module dmm_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  dmm_pkg::in_item_t               in_data_i,
  output logic                            in_stall_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dmm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dmm_pkg::SIZE_W-1:0]      cfg_data_i,
  input  logic [dmm_pkg::FIFO_CNT_W-1:0]  fifo_cnt_i,
  output dmm_pkg::rd_req_t                rd_req_o,
  output dmm_pkg::mem_item_t              item_o,
  output dmm_pkg::pass_mode_e             mode_o
);

  logic [dmm_pkg::COL_W-1:0]     weff_m1_q, weff_m1_d;
  logic [dmm_pkg::SIZE_W-1:0]    heff_q, heff_d;
  dmm_pkg::pass_mode_e           mode_q, mode_d;
  logic                          cfg_hit;

  logic [dmm_pkg::COL_W-1:0]     in_col_q, in_col_d;
  logic [dmm_pkg::IN_ROW_W-1:0]  in_row_q, in_row_d;
  logic [dmm_pkg::COL_W-1:0]     out_col_q, out_col_d;
  logic [dmm_pkg::OUT_ROW_W-1:0] out_row_q, out_row_d;
  logic [dmm_pkg::OUT_ROW_W-1:0] heff_m1;

  dmm_pkg::mem_item_t            item_q, item_d;

  logic accept, live, in_frame, single, emit, last, pos_zero;
  dmm_pkg::centre_t              centre;

  // configuration decode, sizes clipped at write time
  assign cfg_ready_o = 1'b1;

  always_comb begin
    weff_m1_d = weff_m1_q;
    heff_d    = heff_q;
    mode_d    = mode_q;
    cfg_hit   = 1'b0;
    if (cfg_valid_i && cfg_ready_o) begin
      case (dmm_pkg::cfg_idx_e'(cfg_index_i))
        dmm_pkg::CFG_FRAME_WIDTH: begin
          cfg_hit = 1'b1;
          if (cfg_data_i == '0) begin
            weff_m1_d = '0;
          end else if (cfg_data_i > dmm_pkg::SIZE_W'(dmm_pkg::MAX_WIDTH)) begin
            weff_m1_d = dmm_pkg::COL_W'(dmm_pkg::MAX_WIDTH - 1);
          end else begin
            weff_m1_d = dmm_pkg::COL_W'(cfg_data_i - dmm_pkg::SIZE_W'(1));
          end
        end
        dmm_pkg::CFG_FRAME_HEIGHT: begin
          cfg_hit = 1'b1;
          if (cfg_data_i == '0) begin
            heff_d = dmm_pkg::SIZE_W'(1);
          end else if (cfg_data_i > dmm_pkg::SIZE_W'(dmm_pkg::HEIGHT_LIMIT)) begin
            heff_d = dmm_pkg::SIZE_W'(dmm_pkg::HEIGHT_LIMIT);
          end else begin
            heff_d = cfg_data_i;
          end
        end
        dmm_pkg::CFG_PASS_MODE: begin
          cfg_hit = 1'b1;
          case (cfg_data_i[1:0])
            dmm_pkg::MODE_PASS_DIFF:  mode_d = dmm_pkg::MODE_PASS_DIFF;
            dmm_pkg::MODE_PASS_MODEL: mode_d = dmm_pkg::MODE_PASS_MODEL;
            default:                  mode_d = dmm_pkg::MODE_MERGE;
          endcase
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  assign heff_m1 = dmm_pkg::OUT_ROW_W'(heff_q - dmm_pkg::SIZE_W'(1));
  assign mode_o  = mode_q;

  // flow control: room for the item in the memory stage plus a new one
  assign in_stall_o = (fifo_cnt_i == dmm_pkg::FIFO_CNT_W'(dmm_pkg::FIFO_DEPTH)) ||
                      ((fifo_cnt_i == dmm_pkg::FIFO_CNT_W'(dmm_pkg::FIFO_DEPTH - 1)) &&
                       item_q.valid && item_q.emit);

  // position decode of the incoming transaction
  always_comb begin
    accept   = in_valid_i && !in_stall_o;
    pos_zero = (in_row_q == '0) && (in_col_q == '0);
    live     = accept && !(in_data_i.kind && pos_zero);
    in_frame = in_row_q < dmm_pkg::IN_ROW_W'(heff_q);
    single   = (weff_m1_q == '0);
    if (single) begin
      emit = (in_row_q != '0);
    end else begin
      emit = (in_row_q >= dmm_pkg::IN_ROW_W'(2)) ||
             ((in_row_q == dmm_pkg::IN_ROW_W'(1)) && (in_col_q != '0));
    end
    last = emit && (out_row_q == heff_m1) && (out_col_q == weff_m1_q);
  end

  // centre entry, flush and surplus items count as zero pixels
  always_comb begin
    centre = '0;
    if (in_frame && !in_data_i.kind) begin
      centre.diff_fg = (in_data_i.diff_pixel == dmm_pkg::FG_VALUE);
      centre.value   = (mode_q == dmm_pkg::MODE_PASS_DIFF) ? in_data_i.diff_pixel
                                                           : in_data_i.model_pixel;
    end
  end

  // raster counters
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (cfg_hit || (live && last)) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end else if (live) begin
      if (in_col_q == weff_m1_q) begin
        in_col_d = '0;
        in_row_d = in_row_q + dmm_pkg::IN_ROW_W'(1);
      end else begin
        in_col_d = in_col_q + dmm_pkg::COL_W'(1);
      end
      if (emit) begin
        if (out_col_q == weff_m1_q) begin
          out_col_d = '0;
          out_row_d = out_row_q + dmm_pkg::OUT_ROW_W'(1);
        end else begin
          out_col_d = out_col_q + dmm_pkg::COL_W'(1);
        end
      end
    end
  end

  // memory stage item and read request
  always_comb begin
    item_d            = '0;
    item_d.valid      = live;
    item_d.col        = in_col_q;
    item_d.cur_hit    = in_frame && !in_data_i.kind &&
                        (in_data_i.model_pixel == dmm_pkg::FG_VALUE);
    item_d.cur_centre = centre;
    item_d.row_ge1    = (in_row_q != '0);
    item_d.row_ge2    = (in_row_q >= dmm_pkg::IN_ROW_W'(2));
    item_d.emit       = emit;
    item_d.left_ok    = (out_col_q != '0);
    item_d.right_ok   = (out_col_q != weff_m1_q);
    item_d.last       = last;
    item_d.single     = single;
  end

  assign rd_req_o.en   = live;
  assign rd_req_o.addr = in_col_q;
  assign item_o        = item_q;

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weff_m1_q <= dmm_pkg::COL_W'(639);
      heff_q    <= dmm_pkg::SIZE_W'(480);
      mode_q    <= dmm_pkg::MODE_MERGE;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      item_q    <= '0;
    end else begin
      weff_m1_q <= weff_m1_d;
      heff_q    <= heff_d;
      mode_q    <= mode_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      item_q    <= item_d;
    end
  end

`ifndef SYNTHESIS
  // input column never runs past the active width
  a_in_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_col_q <= weff_m1_q)
    else $error("input column beyond frame width");

  // output row stays inside the frame
  a_out_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dmm_pkg::SIZE_W'(out_row_q) < heff_q)
    else $error("output row beyond frame height");

  // the final result of a frame is a real result at the right edge
  a_last_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_q.valid && item_q.last) |-> (item_q.emit && !item_q.right_ok))
    else $error("frame end flagged off the right edge");
`endif

endmodule

// ----- rtl/core/dmm_window.sv -----
// ----------------------------------------------------------------------------
// dmm_window
// Line memory of two rows of model hits and one row of centre entries, read
// in the cycle before the memory stage and written back in it, plus the column
// window that forms the dilated hit and the merged result.
// ----------------------------------------------------------------------------
module dmm_window (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dmm_pkg::rd_req_t     rd_req_i,
  input  dmm_pkg::mem_item_t   item_i,
  input  dmm_pkg::pass_mode_e  mode_i,
  output logic                 push_o,
  output dmm_pkg::out_item_t   push_data_o
);

  dmm_pkg::line_word_t mem_q [dmm_pkg::MAX_WIDTH];
  dmm_pkg::line_word_t rdata_q;
  dmm_pkg::line_word_t fwd_word_q;
  logic                fwd_q;
  dmm_pkg::line_word_t rd_word;
  dmm_pkg::line_word_t wr_word;
  logic                fwd_d;

  // column window: vertical hits of the two previous transactions
  logic                vhit1_q, vhit2_q;
  dmm_pkg::centre_t    centre1_q;
  logic                vhit;
  logic                win_hit;
  dmm_pkg::centre_t    centre;
  logic                mark;

  // read data, bypassed when the previous write hit the same column
  assign rd_word = fwd_q ? fwd_word_q : rdata_q;
  assign fwd_d   = rd_req_i.en && item_i.valid && (item_i.col == rd_req_i.addr);

  // vertical hit over the rows above, at and below the centre row
  assign vhit = (item_i.row_ge1 && rd_word.hit_up1) ||
                (item_i.row_ge2 && rd_word.hit_up2) ||
                item_i.cur_hit;

  // shift the column history down one row
  always_comb begin
    wr_word.hit_up1 = item_i.cur_hit;
    wr_word.hit_up2 = rd_word.hit_up1;
    wr_word.centre  = item_i.cur_centre;
  end

  // line memory
  always_ff @(posedge clk_i) begin
    if (item_i.valid) begin
      mem_q[item_i.col] <= wr_word;
    end
    if (rd_req_i.en) begin
      rdata_q    <= mem_q[rd_req_i.addr];
      fwd_word_q <= wr_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_req_i.en) begin
      fwd_q <= fwd_d;
    end
  end

  // window history
  always_ff @(posedge clk_i) begin
    if (item_i.valid) begin
      vhit1_q   <= vhit;
      vhit2_q   <= vhit1_q;
      centre1_q <= rd_word.centre;
    end
  end

  // horizontal window with edge clipping
  always_comb begin
    if (item_i.single) begin
      win_hit = vhit;
      centre  = rd_word.centre;
    end else begin
      win_hit = (item_i.left_ok && vhit2_q) || vhit1_q || (item_i.right_ok && vhit);
      centre  = centre1_q;
    end
    mark = (mode_i == dmm_pkg::MODE_MERGE) && centre.diff_fg && win_hit;
  end

  assign push_o                 = item_i.valid && item_i.emit;
  assign push_data_o.fg_pixel   = mark ? dmm_pkg::FG_VALUE : centre.value;
  assign push_data_o.merge_mark = mark;
  assign push_data_o.frame_last = item_i.last;

endmodule

// ----- rtl/core/dmm_out_fifo.sv -----
// ----------------------------------------------------------------------------
// dmm_out_fifo
// Small result queue that decouples the memory stage from the receiver and
// reports its fill level for input flow control.
// ----------------------------------------------------------------------------
module dmm_out_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  dmm_pkg::out_item_t              push_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output dmm_pkg::out_item_t              out_data_o,
  output logic [dmm_pkg::FIFO_CNT_W-1:0]  cnt_o
);

  dmm_pkg::out_item_t              entry_q [dmm_pkg::FIFO_DEPTH];
  logic [dmm_pkg::FIFO_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [dmm_pkg::FIFO_CNT_W-1:0]  cnt_q, cnt_d;
  logic                            pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = entry_q[rd_ptr_q];
  assign cnt_o       = cnt_q;
  assign pop         = out_valid_o && !out_stall_i;

  // fill level
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + dmm_pkg::FIFO_CNT_W'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - dmm_pkg::FIFO_CNT_W'(1);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + dmm_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + dmm_pkg::FIFO_PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  // flow control keeps the queue from overflowing
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && (cnt_q == dmm_pkg::FIFO_CNT_W'(dmm_pkg::FIFO_DEPTH))) |-> pop)
    else $error("result queue overflow");
`endif

endmodule

// ----- rtl/core/dilated_mask_merge.sv -----
// ----------------------------------------------------------------------------
// dilated_mask_merge
// Merges a background-model mask with a frame-difference mask, the model
// mask dilated by a 3x3 window clipped at the frame edges.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_stall_o / in_data_i): one pixel pair per
//   transaction in raster order, or a flush item that drains the frame tail.
//   Output channel (out_valid_o / out_stall_i / out_data_o): merged pixels in
//   raster order, frame_last set on the final pixel of each frame.
//   Config channel (cfg_valid_i / cfg_ready_o): frame width, frame height and
//   pass mode; any write to these restarts the frame. Write only while idle.
//   Throughput: one transaction per clock while in_stall_o is low, set by the
//   single line memory that is read and written back once per transaction.
//   Latency: a result is released one row plus one pixel of input
//   transactions after its own pixel (one row when frames are one pixel
//   wide); it then passes the memory stage register (memory read) and the
//   result queue before it is offered.
//   Reset: counters clear, sizes return to 640 x 480, merge mode; the line
//   memory needs no clearing pass.
//   Receiver stall: up to four results queue up; in_stall_o rises when the
//   queue is full, or holds three with a result on the way, until it drains.
// ----------------------------------------------------------------------------
module dilated_mask_merge (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  dmm_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output dmm_pkg::out_item_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dmm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dmm_pkg::SIZE_W-1:0]     cfg_data_i
);

  dmm_pkg::rd_req_t                rd_req;
  dmm_pkg::mem_item_t              item;
  dmm_pkg::pass_mode_e             mode;
  logic                            push;
  dmm_pkg::out_item_t              push_data;
  logic [dmm_pkg::FIFO_CNT_W-1:0]  fifo_cnt;

  // counters, configuration and flow control
  dmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fifo_cnt_i  (fifo_cnt),
    .rd_req_o    (rd_req),
    .item_o      (item),
    .mode_o      (mode)
  );

  // line memory and dilation window
  dmm_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_req_i    (rd_req),
    .item_i      (item),
    .mode_i      (mode),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // result queue
  dmm_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cnt_o       (fifo_cnt)
  );

endmodule
